// ===== rtl/mihv_pkg.sv =====
// shared types, constants and codes of the module image header validator
// no dependencies; imported by the interfaces and all rtl modules

package mihv_pkg;

  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned HDR_POS_W    = $clog2(HEADER_BYTES);
  localparam int unsigned DLEN_BYTES   = 4;

  // header field byte positions
  localparam int unsigned POS_VERSION  = 4;
  localparam int unsigned POS_FLAGS    = 6;
  localparam int unsigned POS_GLOBALS  = 8;
  localparam int unsigned POS_LOCALS   = 10;
  localparam int unsigned POS_ENTRY    = 12;
  localparam int unsigned POS_CODE_LEN = 16;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 34;
  localparam int unsigned SIZE_W = CNT_W + 1;
  localparam int unsigned OFS_W  = 32;
  localparam int unsigned CEND_W = 33;
  localparam int unsigned DEND_W = 34;
  localparam int unsigned SEC_W  = 3;
  localparam int unsigned STAT_W = 4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC,
    CFG_VERSION,
    CFG_MAX_LOCALS,
    CFG_MIN_BYTES
  } cfg_idx_e;

  typedef enum logic [SEC_W-1:0] {
    SEC_HEADER,
    SEC_CODE,
    SEC_DLEN,
    SEC_DATA,
    SEC_BEYOND
  } sec_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_SHORT,
    ST_MAGIC,
    ST_VERSION,
    ST_FLAGS,
    ST_LOCALS,
    ST_CODE_END,
    ST_ENTRY,
    ST_NO_DLEN,
    ST_DATA_END,
    ST_TRAILING
  } stat_e;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] accepted_version;
    logic [15:0] max_entry_locals;
    logic [15:0] min_image_bytes;
  } cfg_t;

  // one tagged beat from the tracker with the fields as captured so far
  typedef struct packed {
    sec_e              section;
    logic [BYTE_W-1:0] byte_val;
    logic [OFS_W-1:0]  ofs;
    logic              last;
    logic [SIZE_W-1:0] size;
    logic              magic_ok;
    logic [15:0]       version;
    logic [15:0]       flags;
    logic [15:0]       globals;
    logic [15:0]       locals;
    logic [31:0]       entry;
    logic [31:0]       code_len;
    logic [31:0]       data_len;
    logic [CEND_W-1:0] code_end;
    logic [CEND_W-1:0] dlen_end;
    logic [DEND_W-1:0] data_end;
  } trk_t;

  typedef struct packed {
    sec_e              section;
    logic [BYTE_W-1:0] byte_out;
    logic [OFS_W-1:0]  section_offset;
    logic              done_res;
    stat_e             status;
    logic [15:0]       global_count;
    logic [15:0]       entry_locals_out;
    logic [31:0]       entry_offset;
    logic [31:0]       code_length;
    logic [31:0]       data_length;
  } res_t;

endpackage

// ===== rtl/mihv_in_if.sv =====
// image byte channel: valid/ready handshake with byte and last flag
// depends on mihv_pkg

interface mihv_in_if import mihv_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] image_byte;
  logic              is_last;

  modport source (output valid, output image_byte, output is_last, input ready);
  modport sink   (input valid, input image_byte, input is_last, output ready);
endinterface

// ===== rtl/mihv_out_if.sv =====
// result channel: valid/ready handshake with the tagged byte and final status
// depends on mihv_pkg

interface mihv_out_if import mihv_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SEC_W-1:0]  section;
  logic [BYTE_W-1:0] byte_out;
  logic [OFS_W-1:0]  section_offset;
  logic              done_res;
  logic [STAT_W-1:0] status;
  logic [15:0]       global_count;
  logic [15:0]       entry_locals_out;
  logic [31:0]       entry_offset;
  logic [31:0]       code_length;
  logic [31:0]       data_length;

  modport source (
    output valid, output section, output byte_out, output section_offset,
    output done_res, output status, output global_count, output entry_locals_out,
    output entry_offset, output code_length, output data_length, input ready
  );
  modport sink (
    input valid, input section, input byte_out, input section_offset,
    input done_res, input status, input global_count, input entry_locals_out,
    input entry_offset, input code_length, input data_length, output ready
  );
endinterface

// ===== rtl/mihv_tracker.sv =====
// per-image byte tracker: byte count, header capture, section boundaries, offsets
// depends on mihv_pkg

module mihv_tracker import mihv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_vld_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_last_i,
  output logic              in_rdy_o,
  output logic              trk_vld_o,
  output trk_t              trk_o,
  input  logic              trk_rdy_i
);

  logic [CNT_W-1:0]     cnt_q;
  logic                 magic_ok_q, magic_ok_d;
  logic [15:0]          version_q, version_d;
  logic [15:0]          flags_q, flags_d;
  logic [15:0]          globals_q, globals_d;
  logic [15:0]          locals_q, locals_d;
  logic [31:0]          entry_q, entry_d;
  logic [31:0]          code_len_q, code_len_d;
  logic [31:0]          data_len_q, data_len_d;
  logic [CEND_W-1:0]    code_end_q, code_end_d;
  logic [CEND_W-1:0]    dlen_end_q, dlen_end_d;
  logic [DEND_W-1:0]    data_end_q, data_end_d;
  sec_e                 sec_q, sec_d;
  logic [OFS_W-1:0]     ofs_q, ofs_d;
  logic [CNT_W-1:0]     cnt_d;
  logic                 trk_vld_q;
  trk_t                 trk_q, trk_d;

  logic                 adv;
  logic                 in_hdr;
  logic [HDR_POS_W-1:0] pos;
  logic [1:0]           dl_idx;

  assign in_rdy_o  = !trk_vld_q || trk_rdy_i;
  assign adv       = in_vld_i && in_rdy_o;
  assign trk_vld_o = trk_vld_q;
  assign trk_o     = trk_q;

  assign in_hdr = cnt_q < CNT_W'(HEADER_BYTES);
  assign pos    = cnt_q[HDR_POS_W-1:0];
  // data length byte index is the offset from the code end, low two bits
  assign dl_idx = cnt_q[1:0] - code_end_q[1:0];

  always_comb begin
    magic_ok_d = magic_ok_q;
    version_d  = version_q;
    flags_d    = flags_q;
    globals_d  = globals_q;
    locals_d   = locals_q;
    entry_d    = entry_q;
    code_len_d = code_len_q;
    data_len_d = data_len_q;
    code_end_d = code_end_q;
    dlen_end_d = dlen_end_q;
    data_end_d = data_end_q;

    // header capture, little-endian
    if (in_hdr) begin
      if (pos < HDR_POS_W'(POS_VERSION)) begin
        if (in_byte_i != cfg_i.magic_word[{pos[1:0], 3'b000} +: 8]) begin
          magic_ok_d = 1'b0;
        end
      end else if (pos < HDR_POS_W'(POS_FLAGS)) begin
        version_d[{pos[0], 3'b000} +: 8] = in_byte_i;
      end else if (pos < HDR_POS_W'(POS_GLOBALS)) begin
        flags_d[{pos[0], 3'b000} +: 8] = in_byte_i;
      end else if (pos < HDR_POS_W'(POS_LOCALS)) begin
        globals_d[{pos[0], 3'b000} +: 8] = in_byte_i;
      end else if (pos < HDR_POS_W'(POS_ENTRY)) begin
        locals_d[{pos[0], 3'b000} +: 8] = in_byte_i;
      end else if (pos < HDR_POS_W'(POS_CODE_LEN)) begin
        entry_d[{pos[1:0], 3'b000} +: 8] = in_byte_i;
      end else if (pos < HDR_POS_W'(POS_CODE_LEN + 4)) begin
        code_len_d[{pos[1:0], 3'b000} +: 8] = in_byte_i;
        // data length is still zero here, so data end equals data length end
        code_end_d = {1'b0, code_len_d} + CEND_W'(HEADER_BYTES);
        dlen_end_d = {1'b0, code_len_d} + CEND_W'(HEADER_BYTES + DLEN_BYTES);
        data_end_d = {1'b0, dlen_end_d};
      end
    end

    // section of this byte
    if (in_hdr) begin
      sec_d = SEC_HEADER;
    end else if ({1'b0, code_end_q} > cnt_q) begin
      sec_d = SEC_CODE;
    end else if ({1'b0, dlen_end_q} > cnt_q) begin
      sec_d = SEC_DLEN;
      data_len_d[{dl_idx, 3'b000} +: 8] = in_byte_i;
      data_end_d = {1'b0, dlen_end_q} + {2'b00, data_len_d};
    end else if (data_end_q > cnt_q) begin
      sec_d = SEC_DATA;
    end else begin
      sec_d = SEC_BEYOND;
    end

    // sections are contiguous, so a new section always starts at offset zero
    if (cnt_q == '0 || sec_d != sec_q) begin
      ofs_d = '0;
    end else if (ofs_q != '1) begin
      ofs_d = ofs_q + 1'b1;
    end else begin
      ofs_d = ofs_q;
    end

    if (cnt_q != '1) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end

    trk_d.section  = sec_d;
    trk_d.byte_val = in_byte_i;
    trk_d.ofs      = ofs_d;
    trk_d.last     = in_last_i;
    trk_d.size     = {1'b0, cnt_q} + SIZE_W'(1);
    trk_d.magic_ok = magic_ok_d;
    trk_d.version  = version_d;
    trk_d.flags    = flags_d;
    trk_d.globals  = globals_d;
    trk_d.locals   = locals_d;
    trk_d.entry    = entry_d;
    trk_d.code_len = code_len_d;
    trk_d.data_len = data_len_d;
    trk_d.code_end = code_end_d;
    trk_d.dlen_end = dlen_end_d;
    trk_d.data_end = data_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      magic_ok_q <= 1'b1;
      version_q  <= '0;
      flags_q    <= '0;
      globals_q  <= '0;
      locals_q   <= '0;
      entry_q    <= '0;
      code_len_q <= '0;
      data_len_q <= '0;
      code_end_q <= CEND_W'(HEADER_BYTES);
      dlen_end_q <= CEND_W'(HEADER_BYTES + DLEN_BYTES);
      data_end_q <= DEND_W'(HEADER_BYTES + DLEN_BYTES);
      sec_q      <= SEC_HEADER;
      ofs_q      <= '0;
      trk_vld_q  <= 1'b0;
    end else begin
      if (in_rdy_o) begin
        trk_vld_q <= in_vld_i;
      end
      if (adv) begin
        if (in_last_i) begin
          // image done: back to a fresh image
          cnt_q      <= '0;
          magic_ok_q <= 1'b1;
          version_q  <= '0;
          flags_q    <= '0;
          globals_q  <= '0;
          locals_q   <= '0;
          entry_q    <= '0;
          code_len_q <= '0;
          data_len_q <= '0;
          code_end_q <= CEND_W'(HEADER_BYTES);
          dlen_end_q <= CEND_W'(HEADER_BYTES + DLEN_BYTES);
          data_end_q <= DEND_W'(HEADER_BYTES + DLEN_BYTES);
          sec_q      <= SEC_HEADER;
          ofs_q      <= '0;
        end else begin
          cnt_q      <= cnt_d;
          magic_ok_q <= magic_ok_d;
          version_q  <= version_d;
          flags_q    <= flags_d;
          globals_q  <= globals_d;
          locals_q   <= locals_d;
          entry_q    <= entry_d;
          code_len_q <= code_len_d;
          data_len_q <= data_len_d;
          code_end_q <= code_end_d;
          dlen_end_q <= dlen_end_d;
          data_end_q <= data_end_d;
          sec_q      <= sec_d;
          ofs_q      <= ofs_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      trk_q <= trk_d;
    end
  end

endmodule

// ===== rtl/mihv_checker.sv =====
// final status check and result register
// depends on mihv_pkg

module mihv_checker import mihv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic trk_vld_i,
  input  trk_t trk_i,
  output logic trk_rdy_o,
  output logic res_vld_o,
  output res_t res_o,
  input  logic res_rdy_i
);

  logic  res_vld_q;
  res_t  res_q, res_d;
  logic  adv;
  logic  mg_ok;
  stat_e status;

  assign trk_rdy_o = !res_vld_q || res_rdy_i;
  assign adv       = trk_vld_i && trk_rdy_o;
  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

  // magic bytes that never arrived read as zero
  assign mg_ok = trk_i.magic_ok
      && !(trk_i.size <= SIZE_W'(1) && cfg_i.magic_word[15:8] != 8'h00)
      && !(trk_i.size <= SIZE_W'(2) && cfg_i.magic_word[23:16] != 8'h00)
      && !(trk_i.size <= SIZE_W'(3) && cfg_i.magic_word[31:24] != 8'h00);

  always_comb begin
    if (trk_i.size < {{(SIZE_W-16){1'b0}}, cfg_i.min_image_bytes}) begin
      status = ST_SHORT;
    end else if (!mg_ok) begin
      status = ST_MAGIC;
    end else if (trk_i.version != cfg_i.accepted_version) begin
      status = ST_VERSION;
    end else if (trk_i.flags != '0) begin
      status = ST_FLAGS;
    end else if (trk_i.locals > cfg_i.max_entry_locals) begin
      status = ST_LOCALS;
    end else if ({2'b00, trk_i.code_end} > trk_i.size) begin
      status = ST_CODE_END;
    end else if (trk_i.entry >= trk_i.code_len) begin
      status = ST_ENTRY;
    end else if ({2'b00, trk_i.dlen_end} > trk_i.size) begin
      status = ST_NO_DLEN;
    end else if ({1'b0, trk_i.data_end} > trk_i.size) begin
      status = ST_DATA_END;
    end else if ({1'b0, trk_i.data_end} != trk_i.size) begin
      status = ST_TRAILING;
    end else begin
      status = ST_OK;
    end

    res_d.section          = trk_i.section;
    res_d.byte_out         = trk_i.byte_val;
    res_d.section_offset   = trk_i.ofs;
    res_d.done_res         = trk_i.last;
    res_d.status           = ST_OK;
    res_d.global_count     = '0;
    res_d.entry_locals_out = '0;
    res_d.entry_offset     = '0;
    res_d.code_length      = '0;
    res_d.data_length      = '0;
    if (trk_i.last) begin
      res_d.status           = status;
      res_d.global_count     = trk_i.globals;
      res_d.entry_locals_out = trk_i.locals;
      res_d.entry_offset     = trk_i.entry;
      res_d.code_length      = trk_i.code_len;
      res_d.data_length      = trk_i.data_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (trk_rdy_o) begin
      res_vld_q <= trk_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/module_image_header_validator_unit.sv =====
// top level of the module image header validator: config registers, input register,
// tracker and checker stages; depends on mihv_pkg, mihv_in_if, mihv_out_if,
// mihv_tracker and mihv_checker

// The block takes a module image one byte per beat, with is_last set on the final
// byte, and returns one result beat per input beat: the byte, its section (header,
// code, data length, data, beyond data) and its saturating offset in that section.
// The result beat of the final byte also carries the status of the whole image and
// the captured header fields; after it the next beat starts a new image. It takes
// one byte every clock cycle while the result side is ready, and each byte passes
// through the input register, the tracker register and the result register before
// its result is valid. The rate is set by the tracker, which updates the byte
// counter, the captured fields and the section boundaries for each byte as it
// accepts it. There is no clearing pass after reset. Configuration registers are
// written through a plain write port (index 0 magic word, 1 accepted version,
// 2 max entry locals, 3 min image bytes) and should only be changed while no
// image is in flight.

module module_image_header_validator_unit import mihv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mihv_in_if.sink               img,
  mihv_out_if.source            res
);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word       <= '0;
      cfg_q.accepted_version <= 16'd1;
      cfg_q.max_entry_locals <= 16'd255;
      cfg_q.min_image_bytes  <= 16'd24;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAGIC:      cfg_q.magic_word       <= cfg_wdata_i;
        CFG_VERSION:    cfg_q.accepted_version <= cfg_wdata_i[15:0];
        CFG_MAX_LOCALS: cfg_q.max_entry_locals <= cfg_wdata_i[15:0];
        CFG_MIN_BYTES:  cfg_q.min_image_bytes  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // input register: holds one beat, refills as soon as the tracker takes it
  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              trk_in_rdy;

  assign img.ready = !in_vld_q || trk_in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (img.ready) begin
      in_vld_q <= img.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (img.valid && img.ready) begin
      in_byte_q <= img.image_byte;
      in_last_q <= img.is_last;
    end
  end

  // tracker stage
  logic trk_vld;
  trk_t trk;
  logic trk_rdy;

  mihv_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_vld_i  (in_vld_q),
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .in_rdy_o  (trk_in_rdy),
    .trk_vld_o (trk_vld),
    .trk_o     (trk),
    .trk_rdy_i (trk_rdy)
  );

  // status check and result register
  logic res_vld;
  res_t res_q;

  mihv_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .trk_vld_i (trk_vld),
    .trk_i     (trk),
    .trk_rdy_o (trk_rdy),
    .res_vld_o (res_vld),
    .res_o     (res_q),
    .res_rdy_i (res.ready)
  );

  assign res.valid            = res_vld;
  assign res.section          = res_q.section;
  assign res.byte_out         = res_q.byte_out;
  assign res.section_offset   = res_q.section_offset;
  assign res.done_res         = res_q.done_res;
  assign res.status           = res_q.status;
  assign res.global_count     = res_q.global_count;
  assign res.entry_locals_out = res_q.entry_locals_out;
  assign res.entry_offset     = res_q.entry_offset;
  assign res.code_length      = res_q.code_length;
  assign res.data_length      = res_q.data_length;

  // a beat stalled in the input register stays put
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !trk_in_rdy |=> in_vld_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("input register lost or changed a stalled beat");

  // header bytes only ever come from the first header-length bytes of an image
  a_hdr_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    trk_vld && trk.section == SEC_HEADER |-> trk.size <= SIZE_W'(HEADER_BYTES))
    else $error("header section tagged past the header");

  // a clean image ends on the data length or inside the data section
  a_ok_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld && res_q.done_res && res_q.status == ST_OK
      |-> res_q.section == SEC_DLEN || res_q.section == SEC_DATA)
    else $error("ok status on a byte outside the data sections");

  // status and captured fields are only shown on the final beat
  a_mid_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld && !res_q.done_res
      |-> res_q.status == ST_OK && res_q.code_length == '0 && res_q.data_length == '0)
    else $error("status or fields set on a non-final beat");

endmodule

// ===== tb/sv/module_image_header_validator_unit_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of module_image_header_validator_unit: streams module images, predicts
// every tagged beat and the final status; depends on mihv_pkg, mihv_in_if, mihv_out_if

module module_image_header_validator_unit_tb;
  import mihv_pkg::*;

  localparam int MAX_REPORTS = 10;  // mismatches printed in full, the rest only counted
  localparam int HOLD_CYCLES = 300; // long receiver hold-off so the pipeline backs up
  localparam int DRAIN_CYCLES = 8;  // three-stage pipeline, with margin

  // expected-beat store and bit-true image tracker
  class image_scoreboard;
    cfg_t              regs;
    logic [CNT_W-1:0]  byte_pos;
    bit                magic_match;
    logic [15:0]       version_f, flags_f, globals_f, locals_f;
    logic [31:0]       entry_f, code_len_f, data_len_f;
    res_t              pending_beats[$];
    int                mismatches;
    int                results;
    int                images;
    bit [ST_TRAILING:0] status_seen;

    function new();
      regs = '{magic_word: 32'h0, accepted_version: 16'd1, max_entry_locals: 16'd255,
               min_image_bytes: 16'd24};
      clear_image();
    endfunction

    function void clear_image();
      byte_pos    = '0;
      magic_match = 1'b1;
      version_f   = '0;
      flags_f     = '0;
      globals_f   = '0;
      locals_f    = '0;
      entry_f     = '0;
      code_len_f  = '0;
      data_len_f  = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        CFG_MAGIC:      regs.magic_word = v;
        CFG_VERSION:    regs.accepted_version = v[15:0];
        CFG_MAX_LOCALS: regs.max_entry_locals = v[15:0];
        CFG_MIN_BYTES:  regs.min_image_bytes = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_image_byte(logic [7:0] b, logic last);
      longint unsigned p, code_end, dlen_end, data_end, ofs, size_b;
      bit              mg;
      res_t            r;
      p = byte_pos;
      if (p < POS_VERSION) begin
        if (b != 8'(regs.magic_word >> (8 * p))) magic_match = 1'b0;
      end else if (p < POS_FLAGS) begin
        version_f[8*(p-POS_VERSION) +: 8] = b;
      end else if (p < POS_GLOBALS) begin
        flags_f[8*(p-POS_FLAGS) +: 8] = b;
      end else if (p < POS_LOCALS) begin
        globals_f[8*(p-POS_GLOBALS) +: 8] = b;
      end else if (p < POS_ENTRY) begin
        locals_f[8*(p-POS_LOCALS) +: 8] = b;
      end else if (p < POS_CODE_LEN) begin
        entry_f[8*(p-POS_ENTRY) +: 8] = b;
      end else if (p < HEADER_BYTES) begin
        code_len_f[8*(p-POS_CODE_LEN) +: 8] = b;
      end
      code_end = 64'(code_len_f) + HEADER_BYTES;
      dlen_end = code_end + DLEN_BYTES;
      r = '0;
      if (p < HEADER_BYTES) begin
        r.section = SEC_HEADER;
        ofs = p;
      end else if (p < code_end) begin
        r.section = SEC_CODE;
        ofs = p - HEADER_BYTES;
      end else if (p < dlen_end) begin
        r.section = SEC_DLEN;
        ofs = p - code_end;
        data_len_f[8*ofs +: 8] = b;
      end else begin
        data_end = dlen_end + data_len_f;
        if (p < data_end) begin
          r.section = SEC_DATA;
          ofs = p - dlen_end;
        end else begin
          r.section = SEC_BEYOND;
          ofs = p - data_end;
        end
      end
      r.byte_out = b;
      r.section_offset = (ofs > 64'hFFFF_FFFF) ? '1 : ofs[31:0];
      if (last) begin
        size_b = p + 1;
        mg = magic_match;
        // magic bytes that never arrived count as zero
        for (longint unsigned i = size_b; i < POS_VERSION; i++)
          if (8'(regs.magic_word >> (8 * i)) != 8'h00) mg = 1'b0;
        r.done_res = 1'b1;
        if (size_b < regs.min_image_bytes)                 r.status = ST_SHORT;
        else if (!mg)                                      r.status = ST_MAGIC;
        else if (version_f != regs.accepted_version)       r.status = ST_VERSION;
        else if (flags_f != 16'h0)                         r.status = ST_FLAGS;
        else if (locals_f > regs.max_entry_locals)         r.status = ST_LOCALS;
        else if (code_end > size_b)                        r.status = ST_CODE_END;
        else if (entry_f >= code_len_f)                    r.status = ST_ENTRY;
        else if (size_b - code_end < DLEN_BYTES)           r.status = ST_NO_DLEN;
        else if (dlen_end + data_len_f > size_b)           r.status = ST_DATA_END;
        else if (dlen_end + data_len_f != size_b)          r.status = ST_TRAILING;
        else                                               r.status = ST_OK;
        r.global_count     = globals_f;
        r.entry_locals_out = locals_f;
        r.entry_offset     = entry_f;
        r.code_length      = code_len_f;
        r.data_length      = data_len_f;
        status_seen[r.status] = 1'b1;
        images++;
        clear_image();
      end else if (byte_pos != '1) begin
        byte_pos++;
      end
      pending_beats.push_back(r);
    endfunction

    function void check_tagged_beat(res_t got);
      res_t  e;
      string diff;
      results++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result beat %0d arrived with nothing outstanding (byte %02h)",
                   results, got.byte_out);
        return;
      end
      e = pending_beats.pop_front();
      diff = "";
      if (got.section !== e.section)
        diff = {diff, $sformatf(" section exp %0d got %0d", e.section, got.section)};
      if (got.byte_out !== e.byte_out)
        diff = {diff, $sformatf(" byte exp %02h got %02h", e.byte_out, got.byte_out)};
      if (got.section_offset !== e.section_offset)
        diff = {diff, $sformatf(" offset exp %0d got %0d", e.section_offset,
                                got.section_offset)};
      if (got.done_res !== e.done_res)
        diff = {diff, $sformatf(" done exp %0b got %0b", e.done_res, got.done_res)};
      if (got.status !== e.status)
        diff = {diff, $sformatf(" status exp %0d got %0d", e.status, got.status)};
      if (got.global_count !== e.global_count)
        diff = {diff, $sformatf(" globals exp %04h got %04h", e.global_count,
                                got.global_count)};
      if (got.entry_locals_out !== e.entry_locals_out)
        diff = {diff, $sformatf(" locals exp %04h got %04h", e.entry_locals_out,
                                got.entry_locals_out)};
      if (got.entry_offset !== e.entry_offset)
        diff = {diff, $sformatf(" entry exp %08h got %08h", e.entry_offset,
                                got.entry_offset)};
      if (got.code_length !== e.code_length)
        diff = {diff, $sformatf(" code_len exp %08h got %08h", e.code_length,
                                got.code_length)};
      if (got.data_length !== e.data_length)
        diff = {diff, $sformatf(" data_len exp %08h got %08h", e.data_length,
                                got.data_length)};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("result beat %0d mismatch:%s", results, diff);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mihv_in_if  img_if ();
  mihv_out_if res_if ();

  module_image_header_validator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .img         (img_if),
    .res         (res_if)
  );

  image_scoreboard sb;
  logic [7:0]      image_q[$];  // bytes of the image about to be streamed
  int              send_idle_pct;
  int              recv_stall_pct;
  bit              hold_request;  // main thread asks the receiver for a long hold-off
  int              hold_left;
  int              bytes_sent;
  int              phases_run;

  // free-running clock, 10 ns period
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // receiver: ready changes on the falling edge; the hold-off is counted here
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: both channels sampled at the rising edge
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (img_if.valid && img_if.ready) sb.note_image_byte(img_if.image_byte, img_if.is_last);
      if (res_if.valid && res_if.ready) begin
        got.section          = sec_e'(res_if.section);
        got.byte_out         = res_if.byte_out;
        got.section_offset   = res_if.section_offset;
        got.done_res         = res_if.done_res;
        got.status           = stat_e'(res_if.status);
        got.global_count     = res_if.global_count;
        got.entry_locals_out = res_if.entry_locals_out;
        got.entry_offset     = res_if.entry_offset;
        got.code_length      = res_if.code_length;
        got.data_length      = res_if.data_length;
        sb.check_tagged_beat(got);
      end
    end
  end

  // one image byte: optional idle gap, then hold valid until accepted;
  // called and returns on a falling edge, with valid still high after the beat
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      img_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    img_if.valid      <= 1'b1;
    img_if.image_byte <= b;
    img_if.is_last    <= last;
    do @(posedge clk_i); while (!img_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_image();
    foreach (image_q[i]) send_byte(image_q[i], i == image_q.size() - 1);
    bytes_sent += image_q.size();
  endtask

  // lower valid and wait until every beat has come back and the pipe is empty
  task automatic drain();
    img_if.valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // one register per cycle; write enable dropped by the caller
  task automatic put_reg(cfg_idx_e idx, logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.write_reg(idx, v);
    @(negedge clk_i);
  endtask

  function automatic void push_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) image_q.push_back(v[8*i +: 8]);
  endfunction

  // mostly well-formed images with random content, some broken on purpose, some noise
  function automatic void make_image(cfg_t c);
    logic [31:0] code_hdr, code_body, entry, dlen_hdr, dlen_body;
    logic [15:0] version, flags, locals;
    int          kind, cut;
    image_q.delete();
    kind = $urandom_range(0, 15);
    if (kind == 15) begin
      // pure noise, often shorter than the header
      repeat ($urandom_range(1, 48)) image_q.push_back(8'($urandom));
      return;
    end
    code_body = $urandom_range(1, 12);
    code_hdr  = code_body;
    entry     = $urandom_range(0, code_body - 1);
    dlen_body = $urandom_range(0, 8);
    dlen_hdr  = dlen_body;
    version   = c.accepted_version;
    flags     = '0;
    locals    = 16'($urandom_range(0, c.max_entry_locals));
    case (kind)
      7:  version ^= 16'($urandom_range(1, 16'hFFFF));
      8:  flags = 16'($urandom_range(1, 16'hFFFF));
      9:  if (c.max_entry_locals != 16'hFFFF)
            locals = 16'($urandom_range(c.max_entry_locals + 1, 16'hFFFF));
      10: entry = code_hdr + $urandom_range(0, 3);
      12: code_hdr = $urandom | 32'h0000_1000;  // code runs past the end
      13: dlen_hdr = $urandom | 32'h0000_1000;  // data runs past the end
      default: ;
    endcase
    push_le(c.magic_word, POS_VERSION);
    push_le(version, POS_FLAGS - POS_VERSION);
    push_le(flags, POS_GLOBALS - POS_FLAGS);
    push_le($urandom, POS_LOCALS - POS_GLOBALS);
    push_le(locals, POS_ENTRY - POS_LOCALS);
    push_le(entry, POS_CODE_LEN - POS_ENTRY);
    push_le(code_hdr, HEADER_BYTES - POS_CODE_LEN);
    repeat (code_body) image_q.push_back(8'($urandom));
    push_le(dlen_hdr, DLEN_BYTES);
    repeat (dlen_body) image_q.push_back(8'($urandom));
    cut = image_q.size();
    case (kind)
      5:  cut = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                             : $urandom_range(1, image_q.size());
      // cut inside the data length field or right at the code end
      6:  cut = HEADER_BYTES + code_body + $urandom_range(0, DLEN_BYTES - 1);
      11: repeat ($urandom_range(1, 5)) image_q.push_back(8'($urandom));
      14: image_q[$urandom_range(0, POS_VERSION - 1)] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    while (image_q.size() > cut) void'(image_q.pop_back());
  endfunction

  task automatic run_phase(cfg_t c, bit write_cfg, int send_pct, int recv_pct, int budget,
                           bit squeeze);
    int start;
    drain();
    if (write_cfg) begin
      put_reg(CFG_MAGIC, c.magic_word);
      put_reg(CFG_VERSION, 32'(c.accepted_version));
      put_reg(CFG_MAX_LOCALS, 32'(c.max_entry_locals));
      put_reg(CFG_MIN_BYTES, 32'(c.min_image_bytes));
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
    end
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) hold_request = 1'b1;
    phases_run++;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      make_image(c);
      send_image();
    end
  endtask

  // stimulus
  initial begin
    cfg_t c;
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_MAGIC;
    cfg_wdata_i    = '0;
    img_if.valid      = 1'b0;
    img_if.image_byte = '0;
    img_if.is_last    = 1'b0;
    res_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    hold_left      = 0;
    bytes_sent     = 0;
    phases_run     = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values: a lone all-ones byte is too short
    image_q = '{8'hFF};
    send_image();
    // smallest clean image: one code byte, empty data, locals at the limit, globals all ones
    image_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h01, 8'h00, 8'h00, 8'h00, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00};
    send_image();

    // reset values, no idling
    c = sb.regs;
    run_phase(c, 1'b0, 0, 0, 200, 1'b0);

    // all-ones magic and version, zero locals limit, no length floor; sender gaps
    c = '{magic_word: 32'hFFFF_FFFF, accepted_version: 16'hFFFF, max_entry_locals: 16'h0,
          min_image_bytes: 16'h0};
    run_phase(c, 1'b1, 72, 0, 250, 1'b0);

    // zero version, widest locals limit; receiver stalls
    c = '{magic_word: $urandom, accepted_version: 16'h0, max_entry_locals: 16'hFFFF,
          min_image_bytes: 16'd24};
    run_phase(c, 1'b1, 0, 72, 250, 1'b0);

    // everything random, short length floor; both sides idle now and then
    c.magic_word       = $urandom;
    c.accepted_version = 16'($urandom);
    c.max_entry_locals = 16'($urandom);
    c.min_image_bytes  = 16'($urandom_range(0, 40));
    run_phase(c, 1'b1, 16, 16, 250, 1'b0);

    // highest length floor: every image is too short
    c.min_image_bytes = 16'hFFFF;
    run_phase(c, 1'b1, 0, 0, 60, 1'b0);

    // back-pressure: long receiver hold-off while the sender keeps streaming
    c = '{magic_word: $urandom, accepted_version: 16'd1, max_entry_locals: 16'($urandom),
          min_image_bytes: 16'h0};
    run_phase(c, 1'b1, 0, 0, 240, 1'b1);

    drain();
    if (sb.pending_beats.size() != 0) begin
      $display("%0d result beats never arrived", sb.pending_beats.size());
      sb.mismatches += sb.pending_beats.size();
    end
    $display("streamed %0d bytes in %0d images under %0d register settings, %0d beats checked",
             bytes_sent, sb.images, phases_run, sb.results);
    $display("final status codes reached: %0d of %0d", $countones(sb.status_seen),
             ST_TRAILING + 1);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatching result beats", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d result beats outstanding", sb.pending_beats.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== module_image_header_validator_unit.f =====
rtl/mihv_pkg.sv
rtl/mihv_in_if.sv
rtl/mihv_out_if.sv
rtl/mihv_tracker.sv
rtl/mihv_checker.sv
rtl/module_image_header_validator_unit.sv
tb/sv/module_image_header_validator_unit_tb.sv
